### sv/quoted_argument_splitter_defines.svh
// Assertion macros used by the checker file of the argument splitter.
`ifndef QUOTED_ARGUMENT_SPLITTER_DEFINES_SVH
`define QUOTED_ARGUMENT_SPLITTER_DEFINES_SVH

// Clocked assertion, masked while reset is asserted.
`define QAS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define QAS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

### sv/qas_pkg.sv
// Types and constants of the quoted argument splitter.
`default_nettype none
package qas_pkg;

    // Special bytes
    localparam logic [7:0] CH_END       = 8'h00;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;

    // Result kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Result buffer
    localparam int BUF_DEPTH = 4;
    localparam int BUF_AW    = $clog2(BUF_DEPTH);
    localparam int BUF_CW    = $clog2(BUF_DEPTH + 1);

    // Parser flags
    typedef struct packed {
        logic in_argument;
        logic single_quoted;
        logic double_quoted;
        logic escape_pending;
        logic any_emitted;
    } t_state;

    // One result request
    typedef struct packed {
        logic [7:0] out_char;
        logic       kind;
        logic       last_of_run;
    } t_result;

    // Up to two results caused by one input byte
    typedef struct packed {
        logic [1:0] num;
        t_result    res0;
        t_result    res1;
    } t_decode;

endpackage
`default_nettype wire

### sv/quoted_argument_splitter.sv
// Accepted bytes' results go into the result buffer and are offered from its head.
// Throughput: one byte per cycle while the output side takes one result per cycle;
// a single quote inside double quotes gives two results, so the output port sets the rate.
// A four-entry result buffer takes new bytes while earlier results wait.
// Reset: synchronous, active low; clears the quoting flags and empties the buffer.
`default_nettype none
module quoted_argument_splitter (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_ch,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_out_char,
    output logic            o_kind,
    output logic            o_last_of_run
);
    import qas_pkg::*;

    t_state              r_state;
    t_state              n_state;
    t_decode             dec;
    t_result             r_buf [BUF_DEPTH];
    logic [BUF_AW-1:0]   r_wr_ptr;
    logic [BUF_AW-1:0]   r_rd_ptr;
    logic [BUF_CW-1:0]   r_count;
    logic [BUF_AW-1:0]   wr_ptr_inc;
    logic                in_accept;
    logic                out_accept;
    t_result             head;

    // Byte decision logic
    qas_decode u_decode (
        .i_ch    (i_ch),
        .i_state (r_state),
        .o_state (n_state),
        .o_dec   (dec)
    );

    // Handshakes: room for two results is needed before a byte is taken
    assign o_in_stall  = (r_count > BUF_CW'(BUF_DEPTH - 2));
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_count != '0);
    assign out_accept  = o_out_valid && !i_out_stall;
    assign wr_ptr_inc  = r_wr_ptr + BUF_AW'(1);

    // Head of the result buffer
    assign head          = r_buf[r_rd_ptr];
    assign o_out_char    = head.out_char;
    assign o_kind        = head.kind;
    assign o_last_of_run = head.last_of_run;

    // Parser flags and buffer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (in_accept) begin
                r_state  <= n_state;
                r_wr_ptr <= r_wr_ptr + BUF_AW'(dec.num);
            end
            if (out_accept) begin
                r_rd_ptr <= r_rd_ptr + BUF_AW'(1);
            end
            r_count <= r_count + (in_accept ? BUF_CW'(dec.num) : BUF_CW'(0))
                               - (out_accept ? BUF_CW'(1) : BUF_CW'(0));
        end
    end

    // Result storage
    always_ff @(posedge i_clk) begin
        if (in_accept && (dec.num != 2'd0)) begin
            r_buf[r_wr_ptr] <= dec.res0;
        end
        if (in_accept && (dec.num == 2'd2)) begin
            r_buf[wr_ptr_inc] <= dec.res1;
        end
    end

endmodule
`default_nettype wire

### sv/qas_decode.sv
// Per-byte decision logic: next parser flags and the results for one byte.
`default_nettype none
module qas_decode (
    input  wire logic [7:0]      i_ch,
    input  wire qas_pkg::t_state i_state,
    output qas_pkg::t_state      o_state,
    output qas_pkg::t_decode     o_dec
);
    import qas_pkg::*;

    logic    blank;
    t_result byte_res;
    t_result end_res;

    assign blank    = (i_ch == CH_SPACE) || ((i_ch >= CH_TAB) && (i_ch <= CH_CR));
    assign byte_res = '{out_char: i_ch, kind: KIND_BYTE, last_of_run: 1'b1};
    assign end_res  = '{out_char: 8'h00, kind: KIND_END, last_of_run: 1'b1};

    // Byte classification against the current quoting state
    always_comb begin
        o_state        = i_state;
        o_dec.num      = 2'd0;
        o_dec.res0     = byte_res;
        o_dec.res1     = byte_res;
        priority if (i_ch == CH_END) begin
            // end of line: close an open argument or an empty line, then clear everything
            if (i_state.in_argument || !i_state.any_emitted) begin
                o_dec.num  = 2'd1;
                o_dec.res0 = end_res;
            end
            o_state = '0;
        end else if (blank && !i_state.single_quoted && !i_state.double_quoted) begin
            // unquoted whitespace; a pending backslash survives
            if (i_state.in_argument) begin
                o_dec.num           = 2'd1;
                o_dec.res0          = end_res;
                o_state.in_argument = 1'b0;
                o_state.any_emitted = 1'b1;
            end
        end else begin
            o_state.in_argument = 1'b1;
            priority if (i_state.escape_pending) begin
                o_dec.num              = 2'd1;
                o_state.escape_pending = 1'b0;
            end else if (i_ch == CH_BACKSLASH) begin
                o_dec.num              = 2'd1;
                o_state.escape_pending = 1'b1;
            end else if (i_state.single_quoted) begin
                if (i_ch == CH_SQUOTE) begin
                    o_state.single_quoted = 1'b0;
                end else begin
                    o_dec.num = 2'd1;
                end
            end else if (i_state.double_quoted) begin
                priority if (i_ch == CH_DQUOTE) begin
                    o_state.double_quoted = 1'b0;
                end else if (i_ch == CH_SQUOTE) begin
                    // single quote inside double quotes comes out escaped
                    o_dec.num  = 2'd2;
                    o_dec.res0 = '{out_char: CH_BACKSLASH, kind: KIND_BYTE,
                                   last_of_run: 1'b0};
                end else begin
                    o_dec.num = 2'd1;
                end
            end else begin
                priority if (i_ch == CH_SQUOTE) begin
                    o_state.single_quoted = 1'b1;
                end else if (i_ch == CH_DQUOTE) begin
                    o_state.double_quoted = 1'b1;
                end else begin
                    o_dec.num = 2'd1;
                end
            end
        end
    end

endmodule
`default_nettype wire

### sv/qas_checker.sv
// Port-level checks of the argument splitter and their bind.
`default_nettype none
`include "quoted_argument_splitter_defines.svh"
module qas_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire logic [7:0] i_ch,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [7:0] o_out_char,
    input wire logic       o_kind,
    input wire logic       o_last_of_run
);
    // A stalled result request holds its payload
    `QAS_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_char) && $stable(o_kind) && $stable(o_last_of_run), "stalled result changed")

    // A stalled byte request stays offered and unchanged
    `QAS_ASSERT(a_in_hold, i_in_valid && o_in_stall |=> i_in_valid && $stable(i_ch), "stalled byte changed")

    // Nothing is offered right after reset
    `QAS_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !o_out_valid, "result offered after reset")

    // An end mark carries a zero byte
    `QAS_ASSERT(a_end_zero, o_out_valid && o_kind |-> o_out_char == 8'h00, "end mark with nonzero byte")

    // An end mark is always flagged as the last result of its run
    `QAS_ASSERT(a_end_last, o_out_valid && o_kind |-> o_last_of_run, "end mark not last of run")

endmodule

bind quoted_argument_splitter qas_checker u_qas_checker (.*);
`default_nettype wire
